// ===== design/vertical_box_filter_line_buffer_unit_assert.svh =====
// assertion macros shared by the checker of the vertical box filter
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef VERTICAL_BOX_FILTER_LINE_BUFFER_UNIT_ASSERT_SVH
`define VERTICAL_BOX_FILTER_LINE_BUFFER_UNIT_ASSERT_SVH

// next-cycle implication, off while reset is low
`define VBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// state seen in the cycle after a reset edge
`define VBF_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

// ===== design/vbf_pkg.sv =====
// shared constants, types and register codes of the vertical box filter
// no dependencies
package vbf_pkg;

    localparam int TAP_COUNT  = 7;
    localparam int LINE_DEPTH = 2048;
    localparam int NUM_LINES  = TAP_COUNT - 1;
    localparam int HALF_LINES = (TAP_COUNT - 1) / 2;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int PIX_W  = 8;
    localparam int ROWS_W = 16;
    localparam int COLS_W = 12;
    localparam int CTR_W  = 16;
    localparam int CMP_W  = CTR_W + 1;
    localparam int CNT_W  = ROWS_W + COLS_W + 1;

    localparam int SUM_W     = $clog2(TAP_COUNT * ((1 << PIX_W) - 1) + 1);
    localparam int DIV_SHIFT = SUM_W + 8;
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + TAP_COUNT - 1) / TAP_COUNT;
    localparam int PROD_W    = SUM_W + DIV_SHIFT;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);
    localparam logic [ROWS_W-1:0]    ROWS_RESET     = ROWS_W'(1080);
    localparam logic [COLS_W-1:0]    COLS_RESET     = COLS_W'(1920);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int HOLD_W = 2;
    localparam logic [HOLD_W-1:0] HOLD_CYCLES = HOLD_W'(2);

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              clr;
        logic [ADDR_W-1:0] wr_addr;
        logic              fwd;
    } t_cell_ctrl;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
        logic             row_end;
    } t_out_item;

endpackage

// ===== design/vbf_cell.sv =====
// one line delay of the cascade: a column memory of one byte per entry
// depends on vbf_pkg
module vbf_cell (
    input  logic                           i_clk,
    input  vbf_pkg::t_cell_ctrl            i_ctrl,
    input  logic [vbf_pkg::PIX_W-1:0]      i_wr_data,
    input  logic [vbf_pkg::SUM_W-1:0]      i_sum,
    output logic [vbf_pkg::PIX_W-1:0]      o_tap,
    output logic [vbf_pkg::SUM_W-1:0]      o_sum
);

    logic [vbf_pkg::PIX_W-1:0] r_mem [0:vbf_pkg::LINE_DEPTH-1];
    logic [vbf_pkg::PIX_W-1:0] r_rd_data;
    logic [vbf_pkg::PIX_W-1:0] r_last;
    logic [vbf_pkg::PIX_W-1:0] w_wr;

    assign w_wr = i_ctrl.clr ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_ctrl.rd_addr];
        end
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= w_wr;
            r_last                <= w_wr;
        end
    end

    // bypass the write of the previous cycle to the same column
    assign o_tap = i_ctrl.fwd ? r_last : r_rd_data;
    assign o_sum = i_sum + vbf_pkg::SUM_W'(o_tap);

endmodule

// ===== design/vbf_out_fifo.sv =====
// small result queue in front of the output channel
// depends on vbf_pkg
module vbf_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  vbf_pkg::t_out_item                 i_wr_item,
    input  logic                               i_rd_en,
    output vbf_pkg::t_out_item                 o_item,
    output logic [vbf_pkg::FIFO_CNT_W-1:0]     o_count
);

    vbf_pkg::t_out_item                r_mem [0:vbf_pkg::FIFO_DEPTH-1];
    logic [vbf_pkg::FIFO_PTR_W-1:0]    r_wr_ptr;
    logic [vbf_pkg::FIFO_PTR_W-1:0]    r_rd_ptr;
    logic [vbf_pkg::FIFO_CNT_W-1:0]    r_count;
    logic [vbf_pkg::FIFO_PTR_W-1:0]    n_wr_ptr;
    logic [vbf_pkg::FIFO_PTR_W-1:0]    n_rd_ptr;
    logic [vbf_pkg::FIFO_CNT_W-1:0]    n_count;

    localparam logic [vbf_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        vbf_pkg::FIFO_PTR_W'(vbf_pkg::FIFO_DEPTH - 1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== design/vertical_box_filter_line_buffer_unit.sv =====
// vertical box filter over a raster pixel stream, top level
// depends on vbf_pkg, vbf_cell, vbf_out_fifo
//
// pixels enter on i_valid/o_ready in raster order, one item per pixel; after the
// frame_rows*frame_cols pixels of a frame come frame_cols*(taps-1)/2 drain items
// whose pixel is ignored. results leave on o_valid/i_ready with frame_start and
// row_end marks; the first frame_cols*(taps-1)/2 items of a frame give none.
// frame_rows (index 0) and frame_cols (index 1) are written on the cfg channel,
// which is always ready; o_ready drops after each write while the
// frame length is recomputed.
// a result passes stages s1, s2 and s3 and the result queue on its way out, and
// one item is taken every cycle while o_ready is high: the column memories are
// read when an item is accepted and written back in the next cycle, with a
// bypass for the same column. after reset a clearing pass zeroes all LINE_DEPTH
// (2048) column entries, one column a cycle, with o_ready low; the memories then
// persist across frames. a stalled receiver fills an eight-entry result queue,
// and o_ready falls once the queue and the three pipeline stages could fill it.
module vertical_box_filter_line_buffer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [vbf_pkg::PIX_W-1:0]          i_pixel_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [vbf_pkg::PIX_W-1:0]          o_pixel_out,
    output logic                               o_frame_start,
    output logic                               o_row_end,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vbf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [vbf_pkg::ADDR_W-1:0] ADDR_LAST =
        vbf_pkg::ADDR_W'(vbf_pkg::LINE_DEPTH - 1);
    localparam logic [vbf_pkg::CTR_W-1:0] CTR_MAX = '1;

    // configuration and derived frame lengths
    logic [vbf_pkg::ROWS_W-1:0]  r_rows;
    logic [vbf_pkg::COLS_W-1:0]  r_cols;
    logic [vbf_pkg::CNT_W-1:0]   r_n_in;
    logic [vbf_pkg::CNT_W-1:0]   r_lag;
    logic [vbf_pkg::CNT_W-1:0]   r_total;
    logic [vbf_pkg::HOLD_W-1:0]  r_hold;

    // clearing pass
    logic                        r_clearing;
    logic [vbf_pkg::ADDR_W-1:0]  r_clr_addr;

    // frame counters
    logic [vbf_pkg::CNT_W-1:0]   r_item_count;
    logic [vbf_pkg::CTR_W-1:0]   r_in_col;
    logic [vbf_pkg::ADDR_W-1:0]  r_addr;
    logic [vbf_pkg::CTR_W-1:0]   r_out_col;
    logic [vbf_pkg::CTR_W-1:0]   r_out_row;
    logic [vbf_pkg::CNT_W-1:0]   n_item_count;
    logic [vbf_pkg::CTR_W-1:0]   n_in_col;
    logic [vbf_pkg::ADDR_W-1:0]  n_addr;
    logic [vbf_pkg::CTR_W-1:0]   n_out_col;
    logic [vbf_pkg::CTR_W-1:0]   n_out_row;

    // pipeline stages
    logic                        r_s1_valid;
    logic                        r_s1_out;
    logic                        r_s1_fs;
    logic                        r_s1_re;
    logic [vbf_pkg::ADDR_W-1:0]  r_s1_addr;
    logic [vbf_pkg::PIX_W-1:0]   r_s1_pix;
    logic                        r_s2_valid;
    logic                        r_s2_out;
    logic                        r_s2_fs;
    logic                        r_s2_re;
    logic [vbf_pkg::ADDR_W-1:0]  r_s2_addr;
    logic [vbf_pkg::SUM_W-1:0]   r_s2_sum;
    logic                        r_s3_valid;
    logic                        r_s3_out;
    logic                        r_s3_fs;
    logic                        r_s3_re;
    logic [vbf_pkg::PROD_W-1:0]  r_s3_prod;

    logic                        w_in_acc;
    logic                        w_go;
    logic                        w_in_data;
    logic                        w_produce;
    logic                        w_last_col;
    logic                        w_last_row;
    logic                        w_in_last;
    logic                        w_frame_end;
    logic                        w_first;
    logic [vbf_pkg::PIX_W-1:0]   w_pix;
    logic [vbf_pkg::CMP_W-1:0]   w_cols_m1;
    logic [vbf_pkg::CMP_W-1:0]   w_rows_m1;
    logic [1:0]                  w_inflight;
    logic [vbf_pkg::FIFO_CNT_W:0] w_credit;

    vbf_pkg::t_cell_ctrl         w_ctrl;
    logic [vbf_pkg::PIX_W-1:0]   w_tap [0:vbf_pkg::NUM_LINES-1];
    logic [vbf_pkg::SUM_W-1:0]   w_sum [0:vbf_pkg::NUM_LINES];

    vbf_pkg::t_out_item          w_fifo_in;
    vbf_pkg::t_out_item          w_fifo_out;
    logic [vbf_pkg::FIFO_CNT_W-1:0] w_fifo_count;
    logic                        w_fifo_wr;
    logic                        w_fifo_rd;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= vbf_pkg::ROWS_RESET;
            r_cols <= vbf_pkg::COLS_RESET;
            r_hold <= vbf_pkg::HOLD_CYCLES;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_hold <= vbf_pkg::HOLD_CYCLES;
                case (i_cfg_index)
                    vbf_pkg::REG_FRAME_ROWS: r_rows <= i_cfg_data[vbf_pkg::ROWS_W-1:0];
                    vbf_pkg::REG_FRAME_COLS: r_cols <= i_cfg_data[vbf_pkg::COLS_W-1:0];
                    default: ;
                endcase
            end else if (r_hold != '0) begin
                r_hold <= r_hold - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n_in  <= vbf_pkg::CNT_W'(r_rows) * vbf_pkg::CNT_W'(r_cols);
        r_lag   <= vbf_pkg::CNT_W'(r_cols) * vbf_pkg::CNT_W'(vbf_pkg::HALF_LINES);
        r_total <= r_n_in + r_lag;
    end

    // clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // input side
    assign w_inflight = 2'(r_s1_valid) + 2'(r_s2_valid) + 2'(r_s3_valid);
    assign w_credit   = (vbf_pkg::FIFO_CNT_W + 1)'(w_fifo_count)
                      + (vbf_pkg::FIFO_CNT_W + 1)'(w_inflight);
    assign o_ready    = !r_clearing && (r_hold == '0)
                      && (w_credit < (vbf_pkg::FIFO_CNT_W + 1)'(vbf_pkg::FIFO_DEPTH));
    assign w_in_acc   = i_valid && o_ready;
    // a frame with zero columns ignores the item
    assign w_go       = w_in_acc && (r_cols != '0);

    assign w_cols_m1   = vbf_pkg::CMP_W'(r_cols) - 1'b1;
    assign w_rows_m1   = vbf_pkg::CMP_W'(r_rows) - 1'b1;
    assign w_in_data   = r_item_count < r_n_in;
    assign w_produce   = r_item_count >= r_lag;
    assign w_pix       = w_in_data ? i_pixel_in : '0;
    assign w_last_col  = {1'b0, r_out_col} == w_cols_m1;
    assign w_last_row  = {1'b0, r_out_row} == w_rows_m1;
    assign w_in_last   = {1'b0, r_in_col} == w_cols_m1;
    assign w_first     = (r_out_row == '0) && (r_out_col == '0);
    assign w_frame_end = ({1'b0, r_item_count} + 1'b1) >= {1'b0, r_total};

    always_comb begin
        n_item_count = r_item_count + 1'b1;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        if (w_produce) begin
            if (w_last_col) begin
                n_out_col = '0;
                n_out_row = w_last_row ? '0 : r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
        if (w_in_last || (r_in_col == CTR_MAX)) begin
            n_in_col = w_in_last ? '0 : r_in_col + 1'b1;
            n_addr   = '0;
        end else begin
            n_in_col = r_in_col + 1'b1;
            n_addr   = (r_addr == ADDR_LAST) ? '0 : r_addr + 1'b1;
        end
        if (w_frame_end) begin
            n_item_count = '0;
            n_in_col     = '0;
            n_addr       = '0;
            n_out_col    = '0;
            n_out_row    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
            r_in_col     <= '0;
            r_addr       <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
        end else if (w_go) begin
            r_item_count <= n_item_count;
            r_in_col     <= n_in_col;
            r_addr       <= n_addr;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_go;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_out  <= w_produce;
        r_s1_fs   <= w_first;
        r_s1_re   <= w_last_col;
        r_s1_addr <= r_addr;
        r_s1_pix  <= w_pix;
        r_s2_out  <= r_s1_out;
        r_s2_fs   <= r_s1_fs;
        r_s2_re   <= r_s1_re;
        r_s2_addr <= r_s1_addr;
        r_s2_sum  <= w_sum[vbf_pkg::NUM_LINES];
        r_s3_out  <= r_s2_out;
        r_s3_fs   <= r_s2_fs;
        r_s3_re   <= r_s2_re;
        r_s3_prod <= vbf_pkg::PROD_W'(r_s2_sum) * vbf_pkg::PROD_W'(vbf_pkg::DIV_MULT);
    end

    // chain of line cells
    always_comb begin
        w_ctrl.rd_en   = w_go;
        w_ctrl.rd_addr = r_addr;
        w_ctrl.wr_en   = r_s1_valid || r_clearing;
        w_ctrl.clr     = r_clearing;
        w_ctrl.wr_addr = r_clearing ? r_clr_addr : r_s1_addr;
        w_ctrl.fwd     = r_s2_valid && (r_s2_addr == r_s1_addr);
    end

    assign w_sum[0] = vbf_pkg::SUM_W'(r_s1_pix);

    for (genvar k = 0; k < vbf_pkg::NUM_LINES; k++) begin : g_cell
        logic [vbf_pkg::PIX_W-1:0] w_wr_data;
        if (k == vbf_pkg::NUM_LINES - 1) begin : g_newest
            assign w_wr_data = r_s1_pix;
        end else begin : g_older
            assign w_wr_data = w_tap[k+1];
        end
        vbf_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_wr_data (w_wr_data),
            .i_sum     (w_sum[k]),
            .o_tap     (w_tap[k]),
            .o_sum     (w_sum[k+1])
        );
    end

    // result queue
    assign w_fifo_wr             = r_s3_valid && r_s3_out;
    assign w_fifo_in.pixel       = r_s3_prod[vbf_pkg::DIV_SHIFT +: vbf_pkg::PIX_W];
    assign w_fifo_in.frame_start = r_s3_fs;
    assign w_fifo_in.row_end     = r_s3_re;
    assign w_fifo_rd             = o_valid && i_ready;

    vbf_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_fifo_wr),
        .i_wr_item (w_fifo_in),
        .i_rd_en   (w_fifo_rd),
        .o_item    (w_fifo_out),
        .o_count   (w_fifo_count)
    );

    assign o_valid       = w_fifo_count != '0;
    assign o_pixel_out   = w_fifo_out.pixel;
    assign o_frame_start = w_fifo_out.frame_start;
    assign o_row_end     = w_fifo_out.row_end;

endmodule

// ===== design/vbf_checker.sv =====
// port-level checks of the vertical box filter and their bind
// depends on vbf_pkg and the assertion macro header
`include "vertical_box_filter_line_buffer_unit_assert.svh"

module vbf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [vbf_pkg::PIX_W-1:0]          o_pixel_out,
    input logic                               o_frame_start,
    input logic                               o_row_end,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready
);

    logic w_in_acc;

    assign w_in_acc = i_valid && o_ready;

    `VBF_ASSERT_RESET(a_reset_quiet, !o_valid && !o_ready, "busy right after reset")
    `VBF_ASSERT_NEXT(a_cfg_hold, i_cfg_valid && o_cfg_ready, !o_ready, "item taken after cfg write")
    `VBF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_pixel_out) && $stable(o_frame_start) && $stable(o_row_end),
        "stalled result changed")
    `VBF_ASSERT_NEXT(a_min_latency, !o_valid && !$past(w_in_acc, 3), !o_valid, "result too early")

endmodule

bind vertical_box_filter_line_buffer_unit vbf_checker u_vbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_pixel_out   (o_pixel_out),
    .o_frame_start (o_frame_start),
    .o_row_end     (o_row_end),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

// ===== verif/vbf_result_checker.sv =====
`timescale 1ns / 1ps
// result checker for the vertical box filter: keeps its own line store, counters and
// frame registers, works out each filtered pixel and compares it with the output channel
// depends on vbf_pkg
module vbf_result_checker
    import vbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [PIX_W-1:0]      i_res_pixel,
    input  logic                  i_res_frame_start,
    input  logic                  i_res_row_end,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    logic [PIX_W-1:0]  line_mem [LINE_DEPTH][NUM_LINES];
    logic [ROWS_W-1:0] rows_q;
    logic [COLS_W-1:0] cols_q;
    logic [31:0]       item_idx;
    logic [CTR_W-1:0]  in_col;
    logic [CTR_W-1:0]  out_col;
    logic [CTR_W-1:0]  out_row;
    t_out_item         predicted_pixels [$];
    int                fail_total = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_total++;
    endtask

    // one item through the column cascade, queueing the filtered pixel once past the lag
    task automatic shift_window(input logic [PIX_W-1:0] pixel);
        logic [31:0]      pix_total;
        logic [31:0]      lag;
        logic [31:0]      frame_len;
        logic [31:0]      sum;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] taps [NUM_LINES];
        int               addr;
        t_out_item        res;
        pix_total = 32'(rows_q) * 32'(cols_q);
        lag       = 32'(cols_q) * 32'(HALF_LINES);
        frame_len = pix_total + lag;
        if (frame_len == 0)
            return;
        pix  = (item_idx < pix_total) ? pixel : '0;
        addr = int'(in_col) % LINE_DEPTH;
        for (int k = 0; k < NUM_LINES; k++)
            taps[k] = line_mem[addr][k];
        for (int k = 0; k < NUM_LINES - 1; k++)
            line_mem[addr][k] = taps[k + 1];
        line_mem[addr][NUM_LINES - 1] = pix;

        if (item_idx >= lag) begin
            sum = 32'(pix);
            for (int k = 0; k < NUM_LINES; k++)
                sum = sum + 32'(taps[k]);
            res.pixel       = PIX_W'(sum / 32'(TAP_COUNT));
            res.frame_start = (out_row == '0) && (out_col == '0);
            res.row_end     = (32'(out_col) == 32'(cols_q) - 32'd1);
            predicted_pixels.push_back(res);
            if (res.row_end) begin
                out_col = '0;
                out_row = (32'(out_row) == 32'(rows_q) - 32'd1) ? '0 : out_row + 1'b1;
            end else begin
                out_col = out_col + 1'b1;
            end
        end

        in_col = (32'(in_col) == 32'(cols_q) - 32'd1) ? '0 : in_col + 1'b1;
        if (item_idx + 32'd1 >= frame_len) begin
            item_idx = '0;
            in_col   = '0;
            out_col  = '0;
            out_row  = '0;
        end else begin
            item_idx = item_idx + 32'd1;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rows_q   = ROWS_RESET;
            cols_q   = COLS_RESET;
            item_idx = '0;
            in_col   = '0;
            out_col  = '0;
            out_row  = '0;
            for (int a = 0; a < LINE_DEPTH; a++)
                for (int k = 0; k < NUM_LINES; k++)
                    line_mem[a][k] = '0;
            predicted_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_ROWS: rows_q = i_cfg_data[ROWS_W-1:0];
                    REG_FRAME_COLS: cols_q = i_cfg_data[COLS_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready)
                shift_window(i_pixel);
            if (i_res_valid && i_res_ready) begin
                if (predicted_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected item, pixel_out %0d", i_res_pixel));
                end else begin
                    want = predicted_pixels.pop_front();
                    if (i_res_pixel !== want.pixel)
                        report_mismatch($sformatf("pixel_out got %0d want %0d",
                                                  i_res_pixel, want.pixel));
                    if (i_res_frame_start !== want.frame_start)
                        report_mismatch($sformatf("frame_start got %b want %b",
                                                  i_res_frame_start, want.frame_start));
                    if (i_res_row_end !== want.row_end)
                        report_mismatch($sformatf("row_end got %b want %b",
                                                  i_res_row_end, want.row_end));
                end
            end
        end
        o_pending    <= predicted_pixels.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// top of the vertical box filter testbench: clock, reset, pixel and register stimulus
// with random idling, and the verdict; depends on vbf_pkg, the unit and vbf_result_checker
module testbench;
    import vbf_pkg::*;

    localparam int RUN_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int LONG_HOLD     = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(8'hFE);

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  pix_valid       = 1'b0;
    logic                  pix_ready;
    logic [PIX_W-1:0]      pixel           = '0;
    logic                  res_valid;
    logic                  res_ready       = 1'b0;
    logic [PIX_W-1:0]      res_pixel;
    logic                  res_frame_start;
    logic                  res_row_end;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;
    int                    pending;
    int                    fail_count;

    logic [ROWS_W-1:0] cur_rows;
    logic [COLS_W-1:0] cur_cols;
    int                frame_pos;
    int                calm_items;
    logic              long_hold_req  = 1'b0;
    logic              long_hold_done = 1'b0;
    int                stall_left     = 0;
    int                calm_left      = 0;

    vertical_box_filter_line_buffer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (pix_valid),
        .o_ready       (pix_ready),
        .i_pixel_in    (pixel),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_pixel_out   (res_pixel),
        .o_frame_start (res_frame_start),
        .o_row_end     (res_row_end),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    vbf_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pix_valid       (pix_valid),
        .i_pix_ready       (pix_ready),
        .i_pixel           (pixel),
        .i_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .i_res_pixel       (res_pixel),
        .i_res_frame_start (res_frame_start),
        .i_res_row_end     (res_row_end),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic int frame_items();
        return int'(cur_rows) * int'(cur_cols) + int'(cur_cols) * HALF_LINES;
    endfunction

    function automatic int to_frame_end();
        int len;
        len = frame_items();
        if (len == 0)
            return 0;
        return (frame_pos + 1 >= len) ? 1 : len - frame_pos;
    endfunction

    // receiver side: random stalls, calm stretches and one long hold-off
    always @(posedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            stall_left     <= LONG_HOLD;
            res_ready      <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ready  <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            res_ready <= 1'b1;
        end else begin
            res_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                calm_left <= $urandom_range(30, 120);
            else
                stall_left <= idle_len();
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        int len;
        if (calm_items > 0) begin
            gap = 0;
            calm_items--;
        end else if ($urandom_range(0, 15) == 0) begin
            gap        = 0;
            calm_items = $urandom_range(20, 80);
        end else begin
            gap = idle_len();
        end
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_valid <= 1'b1;
        pixel     <= pix;
        @(posedge i_clk);
        while (!pix_ready)
            @(posedge i_clk);
        len = frame_items();
        if (len != 0)
            frame_pos = (frame_pos + 1 >= len) ? 0 : frame_pos + 1;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(PIX_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_ROWS: cur_rows = data[ROWS_W-1:0];
            REG_FRAME_COLS: cur_cols = data[COLS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [ROWS_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols_data);
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_FRAME_COLS, cols_data);
    endtask

    // no item in flight and every predicted pixel seen
    task automatic wait_idle();
        pix_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int                    random_sent;
        int                    pick;
        int                    count;
        int                    len;
        logic [ROWS_W-1:0]     rows;
        logic [COLS_W-1:0]     cols;
        logic [CFG_DATA_W-1:0] cols_data;
        cur_rows   = ROWS_RESET;
        cur_cols   = COLS_RESET;
        frame_pos  = 0;
        calm_items = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(8'hFF);
        wait_idle();
        write_reg(REG_SPARE, 16'hFFFF);
        // single pixel frames
        set_frame(16'd1, 16'd1);
        repeat (to_frame_end() + frame_items()) send_pixel(8'hFF);
        wait_idle();
        // drain items only
        set_frame(16'd0, 16'd2);
        repeat (to_frame_end()) send_random(1);
        wait_idle();
        // zero columns, upper data bits set: items ignored
        set_frame(16'd3, 16'hF000);
        send_random(3);
        wait_idle();
        set_frame(16'd2, 16'h1002);
        for (int i = 0; i < 10; i++)
            send_pixel(i[0] ? 8'h00 : 8'hFF);
        wait_idle();

        // widest rows and columns, left partway through the frame
        set_frame(16'hFFFF, 16'hFFFF);
        send_random(40);
        wait_idle();

        // shrink mid-frame, then let the receiver hold off while frames stream in
        set_frame(16'd4, 16'd6);
        long_hold_req <= 1'b1;
        send_random(to_frame_end() + 3 * frame_items());

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            pick = $urandom_range(0, 19);
            rows = ROWS_W'($urandom_range(1, 6));
            cols = COLS_W'($urandom_range(1, 10));
            case (pick)
                0: begin
                    rows = 16'hFFFF;
                    cols = COLS_W'($urandom_range(1, 4));
                end
                1: begin
                    rows = ROWS_W'($urandom_range(1, 3));
                    cols = COLS_W'(LINE_DEPTH);
                end
                2: rows = '0;
                3: cols = '0;
                default: ;
            endcase
            cols_data = {4'($urandom), cols};
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_FRAME_ROWS, rows);
                else
                    write_reg(REG_FRAME_COLS, cols_data);
            end else begin
                set_frame(rows, cols_data);
            end
            len = frame_items();
            if (len == 0)
                count = $urandom_range(1, 4);
            else if (len <= 400 && $urandom_range(0, 3) != 0)
                count = to_frame_end() + len * $urandom_range(0, 2);
            else
                count = $urandom_range(10, 150);
            send_random(count);
            if (len != 0)
                random_sent += count;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/vbf_pkg.sv
design/vbf_cell.sv
design/vbf_out_fifo.sv
design/vertical_box_filter_line_buffer_unit.sv
design/vbf_checker.sv
verif/vbf_result_checker.sv
verif/testbench.sv
